/* hw/rtl/polygon_diagonal_overlap_macros.svh */
// Assertion macros used by the checker.
`ifndef POLYGON_DIAGONAL_OVERLAP_MACROS_SVH
`define POLYGON_DIAGONAL_OVERLAP_MACROS_SVH

// Same-cycle implication, clocked on clk and disabled in reset.
`define PDO_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk and disabled in reset.
`define PDO_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/pdo_pkg.sv */
package pdo_pkg;

	// Storage sizes.
	localparam int MAX_VERTS = 8;
	localparam int AW        = $clog2(MAX_VERTS);
	localparam int CNT_W     = $clog2(MAX_VERTS + 1);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_VERTS);

	// Datapath widths.
	localparam int CW    = 24;
	localparam int DW    = CW + 1;
	localparam int PW    = 2 * DW;
	localparam int HW    = PW + 1;
	localparam int QW    = 17;
	localparam int FRAC  = 16;
	localparam int TW    = QW + 1 + DW;
	localparam int ACC_W = DW + CNT_W + 1;

	localparam logic signed [ACC_W:0] SAT_HI = (ACC_W + 1)'((2 ** (CW - 1)) - 1);
	localparam logic signed [ACC_W:0] SAT_LO = (ACC_W + 1)'(-(2 ** (CW - 1)));

	// Register index of the mode bit.
	localparam logic REG_RESOLVE = 1'b0;

	typedef enum logic [1:0] {
		REQ_VERTEX  = 2'd0,
		REQ_CENTER  = 2'd1,
		REQ_COMPUTE = 2'd2
	} req_t;

	typedef struct packed {
		logic [CW-1:0] x;
		logic [CW-1:0] y;
	} pt_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEG,
		ST_EA,
		ST_EDGE,
		ST_A,
		ST_B,
		ST_DIFF,
		ST_MUL,
		ST_H,
		ST_TEST,
		ST_DIV,
		ST_TERM,
		ST_ACC,
		ST_UPD,
		ST_DONE
	} eng_state_t;

	typedef struct packed {
		logic valid;
		pt_t  c;
	} ctr_upd_t;

	typedef struct packed {
		logic done;
		logic overlap;
	} eng_stat_t;

	// Clamp a widened sum to the signed 24-bit range.
	function automatic logic [CW-1:0] sat24(input logic signed [ACC_W:0] v);
		logic [CW-1:0] r;
		if (v > SAT_HI) begin
			r = SAT_HI[CW-1:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[CW-1:0];
		end else begin
			r = v[CW-1:0];
		end
		return r;
	endfunction

endpackage

/* hw/rtl/polygon_diagonal_overlap.sv */
// Loads (vertex or center) produce no result.
// A compute request runs both passes over the segments and edges, and in resolve mode
// also runs the 17-step divider for every crossing found;
// the result is registered when the engine finishes and the output register is free.
// Reset clears the vertex counts, both centers, the mode bit and all control state;
// the vertex memories are not cleared and hold garbage until written.
module polygon_diagonal_overlap (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [2:0]               paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               req_type,
	input  logic                     which_poly,
	input  logic signed [pdo_pkg::CW-1:0] coord_x,
	input  logic signed [pdo_pkg::CW-1:0] coord_y,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     overlap,
	output logic signed [pdo_pkg::CW-1:0] center_x,
	output logic signed [pdo_pkg::CW-1:0] center_y
);

	logic resolve_q;
	logic busy_q;
	logic [pdo_pkg::CNT_W-1:0] cnt_first_q, cnt_second_q;
	pdo_pkg::pt_t ctr_first_q, ctr_second_q;
	logic out_valid_q, overlap_q;
	pdo_pkg::pt_t out_c_q;

	logic accept, ack, we_first, we_second, start;
	pdo_pkg::pt_t wdata, rd_first, rd_second;
	logic [pdo_pkg::AW-1:0] addr_first, addr_second;
	pdo_pkg::eng_stat_t stat;
	pdo_pkg::ctr_upd_t  upd;

	// Configuration port.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == pdo_pkg::REG_RESOLVE) ? {31'b0, resolve_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resolve_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && paddr[2] == pdo_pkg::REG_RESOLVE) begin
			resolve_q <= pwdata[0];
		end
	end

	// Request decode.
	assign in_ready  = !busy_q;
	assign accept    = in_valid && in_ready;
	assign wdata     = '{x: coord_x, y: coord_y};
	assign we_first  = accept && req_type == pdo_pkg::REQ_VERTEX && !which_poly &&
		cnt_first_q < pdo_pkg::MAX_CNT;
	assign we_second = accept && req_type == pdo_pkg::REQ_VERTEX && which_poly &&
		cnt_second_q < pdo_pkg::MAX_CNT;
	assign start     = accept && req_type == pdo_pkg::REQ_COMPUTE;
	assign ack       = stat.done && (!out_valid_q || out_ready);

	pdo_vram u_vram_first (
		.clk   (clk),
		.we    (we_first),
		.waddr (cnt_first_q[pdo_pkg::AW-1:0]),
		.wdata (wdata),
		.raddr (addr_first),
		.rdata (rd_first)
	);

	pdo_vram u_vram_second (
		.clk   (clk),
		.we    (we_second),
		.waddr (cnt_second_q[pdo_pkg::AW-1:0]),
		.wdata (wdata),
		.raddr (addr_second),
		.rdata (rd_second)
	);

	pdo_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.ack         (ack),
		.resolve     (resolve_q),
		.cnt_first   (cnt_first_q),
		.cnt_second  (cnt_second_q),
		.ctr_first   (ctr_first_q),
		.ctr_second  (ctr_second_q),
		.rd_first    (rd_first),
		.rd_second   (rd_second),
		.addr_first  (addr_first),
		.addr_second (addr_second),
		.stat        (stat),
		.upd         (upd)
	);

	// Polygon state: counts, centers and the busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			cnt_first_q  <= '0;
			cnt_second_q <= '0;
			ctr_first_q  <= '0;
			ctr_second_q <= '0;
		end else begin
			if (start) busy_q <= 1'b1;
			if (we_first) cnt_first_q <= cnt_first_q + 1'b1;
			if (we_second) cnt_second_q <= cnt_second_q + 1'b1;
			if (accept && req_type == pdo_pkg::REQ_CENTER) begin
				if (which_poly) begin
					ctr_second_q <= wdata;
				end else begin
					ctr_first_q <= wdata;
				end
			end
			if (upd.valid) ctr_first_q <= upd.c;
			if (ack) begin
				busy_q       <= 1'b0;
				cnt_first_q  <= '0;
				cnt_second_q <= '0;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ack) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ack) begin
			overlap_q <= stat.overlap;
			out_c_q   <= ctr_first_q;
		end
	end

	assign out_valid = out_valid_q;
	assign overlap   = overlap_q;
	assign center_x  = out_c_q.x;
	assign center_y  = out_c_q.y;

endmodule

/* hw/rtl/pdo_vram.sv */
module pdo_vram (
	input  logic                   clk,
	input  logic                   we,
	input  logic [pdo_pkg::AW-1:0] waddr,
	input  pdo_pkg::pt_t           wdata,
	input  logic [pdo_pkg::AW-1:0] raddr,
	output pdo_pkg::pt_t           rdata
);

	pdo_pkg::pt_t mem [pdo_pkg::MAX_VERTS];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* hw/rtl/pdo_div.sv */
module pdo_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [pdo_pkg::HW-1:0] num,
	input  logic [pdo_pkg::HW-1:0] den,
	output logic                   done,
	output logic [pdo_pkg::QW-1:0] quo
);

	localparam int SW = $clog2(pdo_pkg::QW + 1);

	logic                   run_q;
	logic                   done_q;
	logic [SW-1:0]          cnt_q;
	logic [pdo_pkg::HW:0]   rem_q;
	logic [pdo_pkg::HW-1:0] den_q;
	logic [pdo_pkg::QW-1:0] quo_q;
	logic                   ge;
	logic [pdo_pkg::HW:0]   rsub;

	// One restoring step per cycle.
	assign ge   = rem_q >= {1'b0, den_q};
	assign rsub = ge ? (rem_q - {1'b0, den_q}) : rem_q;

	// Sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= SW'(pdo_pkg::QW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == SW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
			quo_q <= '0;
		end else if (run_q) begin
			rem_q <= {rsub[pdo_pkg::HW-1:0], 1'b0};
			quo_q <= {quo_q[pdo_pkg::QW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

/* hw/rtl/pdo_engine.sv */
module pdo_engine (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      ack,
	input  logic                      resolve,
	input  logic [pdo_pkg::CNT_W-1:0] cnt_first,
	input  logic [pdo_pkg::CNT_W-1:0] cnt_second,
	input  pdo_pkg::pt_t              ctr_first,
	input  pdo_pkg::pt_t              ctr_second,
	input  pdo_pkg::pt_t              rd_first,
	input  pdo_pkg::pt_t              rd_second,
	output logic [pdo_pkg::AW-1:0]    addr_first,
	output logic [pdo_pkg::AW-1:0]    addr_second,
	output pdo_pkg::eng_stat_t        stat,
	output pdo_pkg::ctr_upd_t         upd
);

	localparam int DW    = pdo_pkg::DW;
	localparam int PW    = pdo_pkg::PW;
	localparam int HW    = pdo_pkg::HW;
	localparam int TW    = pdo_pkg::TW;
	localparam int ACC_W = pdo_pkg::ACC_W;
	localparam int CNT_W = pdo_pkg::CNT_W;
	localparam int AW    = pdo_pkg::AW;

	pdo_pkg::eng_state_t state_q, state_d;

	logic             pass_q;
	logic [CNT_W-1:0] p_q, q_q;
	logic             ov_q;

	pdo_pkg::pt_t s_q, e_q, a_q, b_q;

	logic signed [DW-1:0] desx_s1, desy_s1, dbx_s1, dby_s1, dsax_s1, dsay_s1;
	logic signed [PW-1:0] m0_s2, m1_s2, m2_s2, m3_s2, m4_s2, m5_s2;
	logic signed [HW-1:0] h_s3, n1_s3, n2_s3;
	logic signed [TW-1:0] tx_q, ty_q;
	logic signed [ACC_W-1:0] dx_q, dy_q;

	logic [CNT_W-1:0] na, nb, q_inc, q_nxt;
	logic             q_last;
	logic [AW-1:0]    va_addr, vb_addr;
	pdo_pkg::pt_t     rd_va, rd_vb, ctr_s;
	logic             hit;
	logic [HW-1:0]    num, den;
	logic             div_start, div_done;
	logic [pdo_pkg::QW-1:0] quo;
	logic signed [TW-1:0]    tx_adj, ty_adj, tx_sh, ty_sh;
	logic signed [ACC_W:0]   cx_ext, cy_ext, dx_ext, dy_ext, sum_x, sum_y;

	// Operand routing by pass.
	assign na    = pass_q ? cnt_second : cnt_first;
	assign nb    = pass_q ? cnt_first : cnt_second;
	assign rd_va = pass_q ? rd_second : rd_first;
	assign rd_vb = pass_q ? rd_first : rd_second;
	assign ctr_s = pass_q ? ctr_second : ctr_first;

	assign q_inc  = q_q + 1'b1;
	assign q_last = q_inc == nb;
	assign q_nxt  = q_last ? '0 : q_inc;

	// Memory addresses: segment vertex on one side, edge ends on the other.
	always_comb begin
		va_addr = p_q[AW-1:0];
		vb_addr = (state_q == pdo_pkg::ST_A) ? q_nxt[AW-1:0] : q_q[AW-1:0];
		addr_first  = pass_q ? vb_addr : va_addr;
		addr_second = pass_q ? va_addr : vb_addr;
	end

	// Crossing test on the registered h, n1, n2.
	always_comb begin
		if (h_s3 > 0) begin
			hit = (n1_s3 >= 0) && (n1_s3 < h_s3) && (n2_s3 >= 0) && (n2_s3 < h_s3);
			num = h_s3 - n1_s3;
			den = h_s3;
		end else if (h_s3 < 0) begin
			hit = (n1_s3 <= 0) && (n1_s3 > h_s3) && (n2_s3 <= 0) && (n2_s3 > h_s3);
			num = n1_s3 - h_s3;
			den = -h_s3;
		end else begin
			hit = 1'b0;
			num = '0;
			den = '0;
		end
	end

	assign div_start = (state_q == pdo_pkg::ST_TEST) && hit && resolve;

	pdo_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num),
		.den    (den),
		.done   (div_done),
		.quo    (quo)
	);

	// Truncation of the scaled term toward zero.
	assign tx_adj = tx_q + (tx_q[TW-1] ? TW'((2 ** pdo_pkg::FRAC) - 1) : TW'(0));
	assign ty_adj = ty_q + (ty_q[TW-1] ? TW'((2 ** pdo_pkg::FRAC) - 1) : TW'(0));
	assign tx_sh  = tx_adj >>> pdo_pkg::FRAC;
	assign ty_sh  = ty_adj >>> pdo_pkg::FRAC;

	// Center update: subtract in the first pass, add in the second.
	assign cx_ext = (ACC_W + 1)'($signed(ctr_first.x));
	assign cy_ext = (ACC_W + 1)'($signed(ctr_first.y));
	assign dx_ext = (ACC_W + 1)'(dx_q);
	assign dy_ext = (ACC_W + 1)'(dy_q);
	assign sum_x  = pass_q ? (cx_ext + dx_ext) : (cx_ext - dx_ext);
	assign sum_y  = pass_q ? (cy_ext + dy_ext) : (cy_ext - dy_ext);

	always_comb begin
		upd.valid = (state_q == pdo_pkg::ST_UPD) && resolve;
		upd.c.x   = pdo_pkg::sat24(sum_x);
		upd.c.y   = pdo_pkg::sat24(sum_y);
	end

	assign stat.done    = state_q == pdo_pkg::ST_DONE;
	assign stat.overlap = ov_q & ~resolve;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pdo_pkg::ST_IDLE: if (start) state_d = pdo_pkg::ST_SEG;
			pdo_pkg::ST_SEG: begin
				if (p_q != na) begin
					state_d = pdo_pkg::ST_EA;
				end else if (pass_q) begin
					state_d = pdo_pkg::ST_DONE;
				end
			end
			pdo_pkg::ST_EA:   state_d = (nb == '0) ? pdo_pkg::ST_UPD : pdo_pkg::ST_EDGE;
			pdo_pkg::ST_EDGE: state_d = pdo_pkg::ST_A;
			pdo_pkg::ST_A:    state_d = pdo_pkg::ST_B;
			pdo_pkg::ST_B:    state_d = pdo_pkg::ST_DIFF;
			pdo_pkg::ST_DIFF: state_d = pdo_pkg::ST_MUL;
			pdo_pkg::ST_MUL:  state_d = pdo_pkg::ST_H;
			pdo_pkg::ST_H:    state_d = pdo_pkg::ST_TEST;
			pdo_pkg::ST_TEST: begin
				if (div_start) begin
					state_d = pdo_pkg::ST_DIV;
				end else begin
					state_d = q_last ? pdo_pkg::ST_UPD : pdo_pkg::ST_EDGE;
				end
			end
			pdo_pkg::ST_DIV:  if (div_done) state_d = pdo_pkg::ST_TERM;
			pdo_pkg::ST_TERM: state_d = pdo_pkg::ST_ACC;
			pdo_pkg::ST_ACC:  state_d = q_last ? pdo_pkg::ST_UPD : pdo_pkg::ST_EDGE;
			pdo_pkg::ST_UPD:  state_d = pdo_pkg::ST_SEG;
			pdo_pkg::ST_DONE: if (ack) state_d = pdo_pkg::ST_IDLE;
			default:          state_d = pdo_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pdo_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Loop counters and the hit flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_q <= 1'b0;
			p_q    <= '0;
			q_q    <= '0;
			ov_q   <= 1'b0;
		end else begin
			case (state_q)
				pdo_pkg::ST_IDLE: begin
					pass_q <= 1'b0;
					p_q    <= '0;
					ov_q   <= 1'b0;
				end
				pdo_pkg::ST_SEG: begin
					q_q <= '0;
					if (p_q == na && !pass_q) begin
						pass_q <= 1'b1;
						p_q    <= '0;
					end
				end
				pdo_pkg::ST_TEST: begin
					if (hit) ov_q <= 1'b1;
					if (!div_start) q_q <= q_nxt;
				end
				pdo_pkg::ST_ACC: q_q <= q_nxt;
				pdo_pkg::ST_UPD: p_q <= p_q + 1'b1;
				default: ;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			pdo_pkg::ST_SEG: begin
				s_q  <= ctr_s;
				dx_q <= '0;
				dy_q <= '0;
			end
			pdo_pkg::ST_EA: e_q <= rd_va;
			pdo_pkg::ST_A:  a_q <= rd_vb;
			pdo_pkg::ST_B:  b_q <= rd_vb;
			pdo_pkg::ST_DIFF: begin
				desx_s1 <= DW'($signed(e_q.x)) - DW'($signed(s_q.x));
				desy_s1 <= DW'($signed(e_q.y)) - DW'($signed(s_q.y));
				dbx_s1  <= DW'($signed(b_q.x)) - DW'($signed(a_q.x));
				dby_s1  <= DW'($signed(b_q.y)) - DW'($signed(a_q.y));
				dsax_s1 <= DW'($signed(s_q.x)) - DW'($signed(a_q.x));
				dsay_s1 <= DW'($signed(s_q.y)) - DW'($signed(a_q.y));
			end
			pdo_pkg::ST_MUL: begin
				m0_s2 <= desx_s1 * dby_s1;
				m1_s2 <= dbx_s1 * desy_s1;
				m2_s2 <= dbx_s1 * dsay_s1;
				m3_s2 <= dby_s1 * dsax_s1;
				m4_s2 <= desx_s1 * dsay_s1;
				m5_s2 <= desy_s1 * dsax_s1;
			end
			pdo_pkg::ST_H: begin
				h_s3  <= HW'(m0_s2) - HW'(m1_s2);
				n1_s3 <= HW'(m2_s2) - HW'(m3_s2);
				n2_s3 <= HW'(m4_s2) - HW'(m5_s2);
			end
			pdo_pkg::ST_TERM: begin
				tx_q <= $signed({1'b0, quo}) * desx_s1;
				ty_q <= $signed({1'b0, quo}) * desy_s1;
			end
			pdo_pkg::ST_ACC: begin
				dx_q <= dx_q + ACC_W'(tx_sh);
				dy_q <= dy_q + ACC_W'(ty_sh);
			end
			default: ;
		endcase
	end

endmodule

/* hw/rtl/pdo_checker.sv */
`include "polygon_diagonal_overlap_macros.svh"

module pdo_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic [1:0]                req_type,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic                      overlap,
	input logic [pdo_pkg::CW-1:0]    center_x,
	input logic [pdo_pkg::CW-1:0]    center_y
);

	// A stalled result stays offered.
	`PDO_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

	// A stalled result keeps its payload.
	`PDO_ASSERT_NXT(a_out_stable, out_valid && !out_ready,
		$stable(center_x) && $stable(center_y) && $stable(overlap), "result changed while stalled")

	// A compute request blocks further requests while the engine runs.
	`PDO_ASSERT_NXT(a_busy, in_valid && in_ready && req_type == pdo_pkg::REQ_COMPUTE,
		!in_ready, "request taken during compute")

	// A new result only appears at the end of a compute.
	`PDO_ASSERT_IMP(a_result_src, $rose(out_valid), !$past(in_ready), "result without compute")

endmodule

bind polygon_diagonal_overlap pdo_checker u_pdo_checker (.*);
